[hdl/snt_pkg.sv]
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types, constants, sigmoid table and helpers of the neuron trainer.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int NUM_INPUTS = 3;
  localparam int SIG_DEPTH  = 256;

  localparam int IDX_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int TI_W   = $clog2(SIG_DEPTH + 1);
  localparam int P_W    = 24 + $clog2(SIG_DEPTH + 1);
  localparam int K_W    = P_W - 19;

  localparam int MA_W = 34;
  localparam int MB_W = 22;
  localparam int MP_W = MA_W + MB_W;

  localparam longint unsigned SIG_H = (64'd8 << 30) / SIG_DEPTH;

  localparam logic [1:0] FN_PERC   = 2'd0;
  localparam logic [1:0] FN_DELTA  = 2'd1;
  localparam logic [1:0] FN_LOAD   = 2'd2;
  localparam logic [1:0] FN_PRESET = 2'd3;

  localparam logic [1:0] REG_PRATE = 2'd0;
  localparam logic [1:0] REG_DRATE = 2'd1;
  localparam logic [1:0] REG_THR   = 2'd2;

  localparam logic [15:0] PRATE_RST = 16'd16384;
  localparam logic [15:0] DRATE_RST = 16'd9830;
  localparam logic [31:0] THR_RST   = 32'd655;
  localparam logic signed [23:0] W_RST = 24'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_NET,
    ST_PERC,
    ST_SIGT,
    ST_SIGI,
    ST_FSQ,
    ST_ESQ,
    ST_RD,
    ST_GM,
    ST_UPD,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [1:0] func;
    logic       perc_match;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    state_t           state;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  typedef logic [16:0] sig_tab_t [SIG_DEPTH+1];

  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sig_tab_t sig_build();
    sig_tab_t          tab;
    longint unsigned   one30;
    longint unsigned   term;
    longint unsigned   r;
    longint unsigned   e;
    longint unsigned   v;
    one30 = 64'd1 << 30;
    term  = one30;
    r     = one30;
    e     = one30;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * SIG_H) >> 30, 64'(n));
      if ((n & 1) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      if (k > 0) begin
        e = (e * r + (one30 >> 1)) >> 30;
      end
      v = udiv64((one30 - e) * 64'd131072 + (one30 + e), (one30 + e) << 1);
      tab[k] = v[16:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = sig_build();

  function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
    if (v > 35'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -35'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

[hdl/snt_if.sv]
// ----------------------------------------------------------------------------
// snt_if
// Channel interfaces: training item in, result item out, register write.
// ----------------------------------------------------------------------------
interface snt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] sample_0;
  logic signed [15:0] sample_1;
  logic signed [15:0] sample_2;
  logic signed [15:0] target;
  logic [31:0]        error_preset;

  modport source (output valid, func, sample_0, sample_1, sample_2, target, error_preset,
                  input ready);
  modport sink   (input valid, func, sample_0, sample_1, sample_2, target, error_preset,
                  output ready);
endinterface

interface snt_out_if;
  logic               valid;
  logic               ready;
  logic               ok_flag;
  logic signed [23:0] net_sum;
  logic signed [17:0] activation;
  logic signed [23:0] weight_0;
  logic signed [23:0] weight_1;
  logic signed [23:0] weight_2;
  logic [31:0]        error_total;

  modport source (output valid, ok_flag, net_sum, activation, weight_0, weight_1, weight_2,
                  error_total, input ready);
  modport sink   (input valid, ok_flag, net_sum, activation, weight_0, weight_1, weight_2,
                  error_total, output ready);
endinterface

interface snt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/snt_mul.sv]
// ----------------------------------------------------------------------------
// snt_mul
// Shared signed multiplier used by every multiply step of the trainer.
// ----------------------------------------------------------------------------
module snt_mul (
  input  logic signed [snt_pkg::MA_W-1:0] a,
  input  logic signed [snt_pkg::MB_W-1:0] b,
  output logic signed [snt_pkg::MP_W-1:0] p
);
  import snt_pkg::*;

  always_comb begin
    p = MP_W'(a) * MP_W'(b);
  end

endmodule

[hdl/snt_ctrl.sv]
// ----------------------------------------------------------------------------
// snt_ctrl
// Step sequencer: walks one item through its multiply, sigmoid, update or load steps.
// ----------------------------------------------------------------------------
module snt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  snt_pkg::stat_t stat,
  output snt_pkg::ctl_t  ctl
);
  import snt_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             last;

  assign last = (idx == IDX_W'(NUM_INPUTS - 1));
  assign ctl.state = state;
  assign ctl.idx   = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (stat.start) begin
          if (stat.func == FN_PERC || stat.func == FN_DELTA) begin
            state_next = ST_MAC;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_MAC: begin
        if (last) begin
          state_next = ST_NET;
          idx_next   = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_NET: begin
        state_next = (stat.func == FN_PERC) ? ST_PERC : ST_SIGT;
      end
      ST_PERC: begin
        state_next = stat.perc_match ? ST_DONE : ST_UPD;
      end
      ST_SIGT: state_next = ST_SIGI;
      ST_SIGI: state_next = ST_FSQ;
      ST_FSQ:  state_next = ST_ESQ;
      ST_ESQ:  state_next = ST_RD;
      ST_RD:   state_next = ST_GM;
      ST_GM:   state_next = ST_UPD;
      ST_UPD: begin
        if (last) begin
          state_next = ST_DONE;
          idx_next   = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hdl/single_neuron_online_trainer_core.sv]
// ----------------------------------------------------------------------------
// single_neuron_online_trainer_core
// Three-input neuron trainer: perceptron and delta rule, one shared multiplier.
//
//   channel    dir  contents
//   sample_ch  in   func, sample_0..2, target, error_preset
//   result_ch  out  ok_flag, net_sum, activation, weight_0..2, error_total
//   cfg        in   index, data (perceptron rate, delta rate, threshold)
//
// Perceptron items skip the weight update on a match; delta items always update,
// loads take the load step. Every multiply goes through the one shared multiplier.
// No clearing pass after reset; weights and error sum reset at once.
// A finished result waits in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module single_neuron_online_trainer_core (
  input logic clk,
  input logic rst,
  snt_in_if.sink    sample_ch,
  snt_out_if.source result_ch,
  snt_cfg_if.sink   cfg
);
  import snt_pkg::*;

  stat_t stat;
  ctl_t  ctl;

  logic [15:0] prate;
  logic [15:0] drate;
  logic [31:0] thr;

  logic signed [23:0] w [3];
  logic [31:0]        esum;

  logic [1:0]         func_r;
  logic signed [15:0] x [3];
  logic signed [15:0] t;
  logic [31:0]        ep;
  logic signed [41:0] acc;
  logic signed [23:0] net;
  logic               sgn;
  logic [IDX_W-1:0]   kidx_unused_guard;
  logic [18:0]        q;
  logic [16:0]        tk;
  logic [16:0]        td;
  logic signed [17:0] f;
  logic signed [20:0] e;
  logic [16:0]        d;
  logic [31:0]        rd;
  logic signed [33:0] g;
  logic signed [17:0] act;
  logic               ok;

  logic                    start;
  logic                    out_v;
  logic                    out_free;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [MP_W-1:0]  prod;

  logic signed [42:0] net_rnd;
  logic signed [23:0] net_sat;
  logic [23:0]        net_abs;
  logic [P_W-1:0]     p_tab;
  logic [K_W-1:0]     k_tab;
  logic signed [17:0] tt;
  logic [35:0]        fm_sum;
  logic [16:0]        fm;
  logic [33:0]        dsum;
  logic [42:0]        ee_rnd;
  logic [32:0]        esum_sum;
  logic [31:0]        esum_new;
  logic signed [MP_W-1:0] g_rnd;
  logic signed [MP_W-1:0] u_rnd;
  logic signed [34:0] wsum;

  assign start    = sample_ch.valid && sample_ch.ready;
  assign out_free = !out_v || result_ch.ready;
  assign sample_ch.ready = (ctl.state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign kidx_unused_guard = ctl.idx;

  assign stat.start      = start;
  assign stat.func       = (ctl.state == ST_IDLE) ? sample_ch.func : func_r;
  assign stat.perc_match = (tt == 18'sd0);
  assign stat.out_free   = out_free;

  snt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  snt_mul u_mul (
    .a (ma),
    .b (mb),
    .p (prod)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.state)
      ST_MAC: begin
        ma = MA_W'(w[kidx_unused_guard]);
        mb = MB_W'(x[kidx_unused_guard]);
      end
      ST_PERC: begin
        ma = MA_W'($signed({1'b0, prate}));
        mb = MB_W'(tt);
      end
      ST_SIGI: begin
        ma = MA_W'($signed({1'b0, td}));
        mb = MB_W'($signed({1'b0, q}));
      end
      ST_FSQ: begin
        ma = MA_W'(f);
        mb = MB_W'(f);
      end
      ST_ESQ: begin
        ma = MA_W'(e);
        mb = MB_W'(e);
      end
      ST_RD: begin
        ma = MA_W'($signed({1'b0, drate}));
        mb = MB_W'($signed({1'b0, d}));
      end
      ST_GM: begin
        ma = MA_W'($signed({1'b0, rd}));
        mb = MB_W'(e);
      end
      ST_UPD: begin
        ma = g;
        mb = MB_W'(x[kidx_unused_guard]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    net_rnd  = (43'(acc) + 43'sd2048) >>> 12;
    net_sat  = sat24(net_rnd[34:0]);
    net_abs  = net[23] ? 24'(-net) : 24'(net);
    p_tab    = P_W'(net_abs) * P_W'(SIG_DEPTH);
    k_tab    = p_tab[P_W-1:19];
    tt       = 18'(t) - (sgn ? -18'sd4096 : 18'sd4096);
    fm_sum   = prod[35:0] + 36'd262144;
    fm       = tk + fm_sum[35:19];
    dsum     = 34'h1_0001_0000 - {1'b0, prod[32:0]};
    ee_rnd   = {1'b0, prod[41:0]} + 43'd65536;
    esum_sum = {1'b0, esum} + 33'(ee_rnd[42:17]);
    esum_new = esum_sum[32] ? 32'hFFFF_FFFF : esum_sum[31:0];
    g_rnd    = (prod + MP_W'(524288)) >>> 20;
    u_rnd    = (prod + MP_W'(2097152)) >>> 22;
    wsum     = 35'(w[kidx_unused_guard]) + $signed(u_rnd[34:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prate <= PRATE_RST;
      drate <= DRATE_RST;
      thr   <= THR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PRATE: prate <= cfg.data[15:0];
        REG_DRATE: drate <= cfg.data[15:0];
        REG_THR:   thr   <= cfg.data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        w[i] <= W_RST;
      end
      esum <= '0;
    end else begin
      case (ctl.state)
        ST_ESQ: esum <= esum_new;
        ST_UPD: w[kidx_unused_guard] <= sat24(wsum);
        ST_LOAD: begin
          if (func_r == FN_LOAD) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
              w[i] <= {{4{x[i][15]}}, x[i], 4'b0};
            end
          end else begin
            esum <= ep;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      func_r <= sample_ch.func;
      x[0]   <= sample_ch.sample_0;
      x[1]   <= sample_ch.sample_1;
      x[2]   <= sample_ch.sample_2;
      t      <= sample_ch.target;
      ep     <= sample_ch.error_preset;
      acc    <= '0;
      net    <= '0;
      act    <= '0;
      ok     <= 1'b1;
    end
    case (ctl.state)
      ST_MAC: acc <= acc + prod[41:0];
      ST_NET: begin
        net <= net_sat;
        sgn <= net_sat[23];
      end
      ST_PERC: begin
        act <= sgn ? -18'sd65536 : 18'sd65536;
        ok  <= (tt == 18'sd0);
        g   <= prod[33:0];
      end
      ST_SIGT: begin
        q    <= p_tab[18:0];
        if (k_tab >= K_W'(SIG_DEPTH)) begin
          tk <= SIG_TAB[SIG_DEPTH];
          td <= '0;
        end else begin
          tk <= SIG_TAB[TI_W'(k_tab)];
          td <= SIG_TAB[TI_W'(k_tab) + 1'b1] - SIG_TAB[TI_W'(k_tab)];
        end
      end
      ST_SIGI: begin
        f   <= sgn ? -18'($signed({1'b0, fm})) : 18'($signed({1'b0, fm}));
        act <= sgn ? -18'($signed({1'b0, fm})) : 18'($signed({1'b0, fm}));
      end
      ST_FSQ: begin
        d <= dsum[33:17];
        e <= {t[15], t, 4'b0} - 21'(f);
      end
      ST_ESQ: ok <= (esum_new <= thr);
      ST_RD:  rd <= prod[31:0];
      ST_GM:  g  <= g_rnd[33:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ctl.state == ST_DONE && out_free) begin
      out_v <= 1'b1;
    end else if (result_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.state == ST_DONE && out_free) begin
      result_ch.ok_flag     <= ok;
      result_ch.net_sum     <= net;
      result_ch.activation  <= act;
      result_ch.weight_0    <= (NUM_INPUTS > 0) ? w[0] : '0;
      result_ch.weight_1    <= (NUM_INPUTS > 1) ? w[1] : '0;
      result_ch.weight_2    <= (NUM_INPUTS > 2) ? w[2] : '0;
      result_ch.error_total <= esum;
    end
  end

  assign result_ch.valid = out_v;

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (ctl.state == ST_DONE && out_free) |=> out_v)
    else $error("result not presented after done");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (ctl.state == ST_IDLE) |=> ($stable(w[0]) && $stable(w[1]) && $stable(w[2])))
    else $error("weights moved while idle");

  a_match_skips: assert property (@(posedge clk) disable iff (rst)
    (ctl.state == ST_PERC && stat.perc_match) |=> (ctl.state == ST_DONE))
    else $error("weight update on perceptron match");

  a_esum_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.state == ST_ESQ) |=> (esum >= $past(esum)))
    else $error("error sum decreased");

endmodule

[tb/sv/snt_scoreboard.sv]
// ----------------------------------------------------------------------------
// snt_scoreboard
// Watches the sample, result and register channels of the neuron trainer,
// predicts every result item from its own copy of weights, error sum and
// rates, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module snt_scoreboard
  import snt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  snt_in_if    in_ch,
  snt_out_if   out_ch,
  snt_cfg_if   cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               ok_flag;
    logic signed [23:0] net_sum;
    logic signed [17:0] activation;
    logic signed [23:0] weight [3];
    logic [31:0]        error_total;
  } outcome_t;

  localparam longint ONE30 = 64'd1 << 30;
  localparam longint WMAX  = 8388607;
  localparam longint WMIN  = -8388608;

  longint   tanh_lut [SIG_DEPTH+1];
  longint   wt [3];
  longint   err_acc;
  longint   p_rate;
  longint   d_rate;
  longint   thresh;
  outcome_t pending_q [$];

  function automatic longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint tanh_half(longint net);
    longint a, p, k, q, f;
    a = net < 0 ? -net : net;
    p = a * SIG_DEPTH;
    k = p >>> 19;
    q = p & ((64'sd1 <<< 19) - 1);
    if (k >= SIG_DEPTH) begin
      f = tanh_lut[SIG_DEPTH];
    end else begin
      f = tanh_lut[k] + (((tanh_lut[k+1] - tanh_lut[k]) * q + (64'sd1 <<< 18)) >>> 19);
    end
    return net < 0 ? -f : f;
  endfunction

  function automatic void nudge_weights(longint g, longint x [3]);
    for (int i = 0; i < NUM_INPUTS; i++) begin
      wt[i] = clip(wt[i] + rnd(g * x[i], 22));
    end
  endfunction

  function automatic outcome_t train_step(logic [1:0] fn, longint x [3], longint t,
                                          logic [31:0] preset);
    outcome_t r;
    longint   acc, net, act, s, f, e, d, g;
    acc = 0;
    net = 0;
    act = 0;
    r.ok_flag = 1'b1;
    if (fn == FN_PERC || fn == FN_DELTA) begin
      for (int i = 0; i < NUM_INPUTS; i++) acc += wt[i] * x[i];
      net = clip(rnd(acc, 12));
    end
    case (fn)
      FN_PERC: begin
        s = net < 0 ? -1 : 1;
        act = s * 65536;
        if (t != s * 4096) begin
          r.ok_flag = 1'b0;
          nudge_weights(p_rate * (t - s * 4096), x);
        end
      end
      FN_DELTA: begin
        f = tanh_half(net);
        e = t * 16 - f;
        d = ((64'sd1 <<< 32) - f * f + 65536) >>> 17;
        g = rnd(d_rate * e * d, 20);
        act = f;
        nudge_weights(g, x);
        err_acc += rnd(e * e, 17);
        if (err_acc > 64'sh0FFFFFFFF) err_acc = 64'sh0FFFFFFFF;
        r.ok_flag = err_acc <= thresh;
      end
      FN_LOAD: begin
        for (int i = 0; i < NUM_INPUTS; i++) wt[i] = x[i] * 16;
      end
      default: err_acc = preset;
    endcase
    r.net_sum = net[23:0];
    r.activation = act[17:0];
    for (int i = 0; i < 3; i++) r.weight[i] = (i < NUM_INPUTS) ? wt[i][23:0] : '0;
    r.error_total = err_acc[31:0];
    return r;
  endfunction

  initial begin
    longint unsigned h, term, rr, e;
    h = (64'd8 * ONE30) / SIG_DEPTH;
    term = ONE30;
    rr = ONE30;
    e = ONE30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * h) >> 30) / n;
      rr = (n & 1) ? rr - term : rr + term;
    end
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      if (k > 0) e = (e * rr + (ONE30 >> 1)) >> 30;
      tanh_lut[k] = ((ONE30 - e) * 131072 + (ONE30 + e)) / (2 * (ONE30 + e));
    end
    fail_count = 0;
  end

  assign outstanding = pending_q.size();

  always @(posedge clk) begin
    longint   xs [3];
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < 3; i++) wt[i] = W_RST;
      err_acc = 0;
      p_rate = PRATE_RST;
      d_rate = DRATE_RST;
      thresh = THR_RST;
      pending_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PRATE: p_rate = cfg_ch.data[15:0];
          REG_DRATE: d_rate = cfg_ch.data[15:0];
          REG_THR:   thresh = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (out_ch.ok_flag !== want.ok_flag) begin
            $error("ok_flag expected %0d got %0d", want.ok_flag, out_ch.ok_flag);
            fail_count++;
          end
          if (out_ch.net_sum !== want.net_sum) begin
            $error("net_sum expected %0d got %0d", want.net_sum, out_ch.net_sum);
            fail_count++;
          end
          if (out_ch.activation !== want.activation) begin
            $error("activation expected %0d got %0d", want.activation, out_ch.activation);
            fail_count++;
          end
          if (out_ch.weight_0 !== want.weight[0]) begin
            $error("weight_0 expected %0d got %0d", want.weight[0], out_ch.weight_0);
            fail_count++;
          end
          if (out_ch.weight_1 !== want.weight[1]) begin
            $error("weight_1 expected %0d got %0d", want.weight[1], out_ch.weight_1);
            fail_count++;
          end
          if (out_ch.weight_2 !== want.weight[2]) begin
            $error("weight_2 expected %0d got %0d", want.weight[2], out_ch.weight_2);
            fail_count++;
          end
          if (out_ch.error_total !== want.error_total) begin
            $error("error_total expected %0d got %0d", want.error_total,
                   out_ch.error_total);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        xs[0] = in_ch.sample_0;
        xs[1] = in_ch.sample_1;
        xs[2] = in_ch.sample_2;
        pending_q.push_back(train_step(in_ch.func, xs, longint'(in_ch.target),
                                       in_ch.error_preset));
      end
    end
  end

endmodule

[tb/sv/single_neuron_online_trainer_core_test.sv]
// ----------------------------------------------------------------------------
// single_neuron_online_trainer_core_test
// Drives training, load and preset items plus register writes into the
// neuron trainer with random gaps and result back-pressure; the scoreboard
// beside the block predicts and checks every result item.
// ----------------------------------------------------------------------------
module single_neuron_online_trainer_core_test;
  import snt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;
  int   items_sent = 0;
  bit   no_gaps = 1'b0;

  snt_in_if  sample_if();
  snt_out_if result_if();
  snt_cfg_if cfg_if();

  single_neuron_online_trainer_core dut (
    .clk(clk), .rst(rst), .sample_ch(sample_if), .result_ch(result_if), .cfg(cfg_if)
  );

  snt_scoreboard scoreboard (
    .clk(clk), .rst(rst), .in_ch(sample_if), .out_ch(result_if), .cfg_ch(cfg_if),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial result_if.ready = 1'b0;
  always @(posedge clk) begin
    result_if.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 34);
  end

  task automatic send_item(logic [1:0] fn, logic [15:0] s0, logic [15:0] s1,
                           logic [15:0] s2, logic [15:0] t, logic [31:0] preset);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 34) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.func <= fn;
    sample_if.sample_0 <= s0;
    sample_if.sample_1 <= s1;
    sample_if.sample_2 <= s2;
    sample_if.target <= t;
    sample_if.error_preset <= preset;
    do @(posedge clk); while (!(sample_if.valid && sample_if.ready));
    items_sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    sample_if.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rates(logic [15:0] pr, logic [15:0] dr, logic [31:0] thr);
    drain();
    write_reg(REG_PRATE, {16'h0, pr});
    write_reg(REG_DRATE, {16'h0, dr});
    write_reg(REG_THR, thr);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192) - 4096);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 512) - 256);
    endcase
  endfunction

  task automatic random_items(int count);
    int          roll;
    logic [1:0]  fn;
    logic [15:0] t;
    logic [31:0] preset;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      fn = roll < 38 ? FN_PERC : (roll < 76 ? FN_DELTA : (roll < 88 ? FN_LOAD : FN_PRESET));
      if (fn == FN_PERC) begin
        t = ($urandom_range(9) == 0) ? 16'($urandom) : ($urandom_range(1) ? 16'h1000 : 16'hF000);
      end else begin
        t = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
      end
      preset = $urandom_range(3) == 0 ? 32'hFFFFFFFF - $urandom_range(65535) : $urandom;
      send_item(fn, pick_sample(), pick_sample(), pick_sample(), t, preset);
    end
  endtask

  initial begin
    sample_if.valid = 1'b0;
    sample_if.func = FN_PERC;
    sample_if.sample_0 = '0;
    sample_if.sample_1 = '0;
    sample_if.sample_2 = '0;
    sample_if.target = '0;
    sample_if.error_preset = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PRATE;
    cfg_if.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(FN_PERC, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 0);
    send_item(FN_PERC, 16'h1000, 16'h1000, 16'h1000, 16'hF000, 0);
    send_item(FN_PERC, 16'h0000, 16'h0000, 16'h0000, 16'hF000, 0);
    send_item(FN_PERC, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 0);
    send_item(FN_PERC, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 0);
    send_item(FN_DELTA, 16'h1000, 16'hF000, 16'h0800, 16'h0C00, 0);
    send_item(FN_DELTA, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 0);
    send_item(FN_DELTA, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 0);
    send_item(FN_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 0);
    send_item(FN_PERC, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hF000, 0);
    send_item(FN_DELTA, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
    send_item(FN_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
    send_item(FN_DELTA, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_item(FN_PRESET, 16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF, 32'hFFFFFFFF);
    send_item(FN_DELTA, 16'h1000, 16'h1000, 16'h1000, 16'h8000, 0);
    send_item(FN_PRESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000);
    send_item(FN_LOAD, 16'h0100, 16'hFF00, 16'h0080, 16'h0000, 0);
    send_item(FN_DELTA, 16'h2000, 16'h1000, 16'hE000, 16'h1000, 32'hA5A5A5A5);

    set_rates(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    write_reg(REG_SPARE, 32'h12345678);
    send_item(FN_PERC, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
    send_item(FN_DELTA, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 0);
    random_items(140);

    set_rates(16'h0000, 16'h0000, 32'h00000000);
    random_items(140);

    set_rates(16'($urandom), 16'($urandom), $urandom_range(0, 200000));
    no_gaps = 1'b1;
    random_items(150);
    drain();
    no_gaps = 1'b0;

    set_rates(PRATE_RST, DRATE_RST, THR_RST);
    random_items(150);

    set_rates(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)), $urandom);
    random_items(150);

    drain();
    repeat (30) @(posedge clk);
    $display("Sent %0d items over five rate settings, register extremes included,",
             items_sent);
    $display("covering perceptron and delta training, weight loads and error presets.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
